>>> design/disjoint_interval_set_insert_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the interval set checker
// Clocked property shorthands with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef DISJOINT_INTERVAL_SET_INSERT_ASSERT_SVH
`define DISJOINT_INTERVAL_SET_INSERT_ASSERT_SVH

// same-cycle implication
`define DIS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("interval set checker: property failed");

// next-cycle implication
`define DIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("interval set checker: property failed");

`endif

>>> design/dis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dis_pkg
// Shared types and constants of the disjoint interval set.
// ----------------------------------------------------------------------------
package dis_pkg;

  localparam int MAX_INTERVALS_DEF = 32;
  localparam int VALUE_BITS_DEF    = 16;
  localparam int COUNT_W           = 6;

  // input operation codes
  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_LIST = 1'b1
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_LISTED  = 2'd0,
    ST_ADDED   = 2'd1,
    ST_DROPPED = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  // kinds of table update applied by the cell row
  typedef enum logic [1:0] {
    UPD_JOIN_L = 2'd0,
    UPD_JOIN_R = 2'd1,
    UPD_FUSE   = 2'd2,
    UPD_INSERT = 2'd3
  } upd_e;

  // control broadcast to every cell
  typedef struct packed {
    logic cmp;     // compare the word value against the row, latch flags
    logic upd;     // apply an update of the given kind
    upd_e kind;
    logic rotate;  // shift the row toward cell 0, head wraps to the tail
  } cell_ctrl_t;

endpackage

>>> design/dis_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dis_cell
// One slot of the interval row: holds an interval, compares it against the
// broadcast value and takes data from either neighbor on updates.
// ----------------------------------------------------------------------------
module dis_cell import dis_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_ctrl_t            ctrl_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  occ_i,
  input  logic                  occ_next_i,
  input  logic                  ge_prev_i,
  input  logic                  ge_next_i,
  input  logic [VALUE_BITS-1:0] prev_lo_i,
  input  logic [VALUE_BITS-1:0] prev_hi_i,
  input  logic [VALUE_BITS-1:0] next_lo_i,
  input  logic [VALUE_BITS-1:0] next_hi_i,
  input  logic [VALUE_BITS-1:0] head_lo_i,
  input  logic [VALUE_BITS-1:0] head_hi_i,
  output logic                  ge_o,
  output logic                  covered_o,
  output logic                  join_l_o,
  output logic                  join_r_o,
  output logic [VALUE_BITS-1:0] lo_o,
  output logic [VALUE_BITS-1:0] hi_o
);

  logic [VALUE_BITS-1:0] lo_q, lo_d, hi_q, hi_d;
  logic                  left_q, pos_q, ge_q;
  logic                  at_pos, is_left, tail;

  // compare stage: ge marks cells starting at or below the value
  assign ge_o    = occ_i && (lo_q <= value_i);
  assign at_pos  = !ge_o && ge_prev_i;
  assign is_left = ge_o && !ge_next_i;
  assign tail    = occ_i && !occ_next_i;

  assign covered_o = is_left && (hi_q >= value_i);
  assign join_l_o  = is_left &&
                     (({1'b0, hi_q} + (VALUE_BITS+1)'(1)) == {1'b0, value_i});
  assign join_r_o  = at_pos && occ_i &&
                     ({1'b0, lo_q} == ({1'b0, value_i} + (VALUE_BITS+1)'(1)));

  // position flags held for the update cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 1'b0;
      pos_q  <= 1'b0;
      ge_q   <= 1'b0;
    end else if (ctrl_i.cmp) begin
      left_q <= is_left;
      pos_q  <= at_pos;
      ge_q   <= ge_o;
    end
  end

  // update stage
  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (ctrl_i.rotate) begin
      lo_d = tail ? head_lo_i : next_lo_i;
      hi_d = tail ? head_hi_i : next_hi_i;
    end else if (ctrl_i.upd) begin
      case (ctrl_i.kind)
        UPD_JOIN_L: begin
          if (left_q) hi_d = value_i;
        end
        UPD_JOIN_R: begin
          if (pos_q) lo_d = value_i;
        end
        UPD_FUSE: begin
          // left neighbor swallows the right one, the rest move down
          if (left_q) begin
            hi_d = next_hi_i;
          end else if (!ge_q) begin
            lo_d = next_lo_i;
            hi_d = next_hi_i;
          end
        end
        UPD_INSERT: begin
          if (pos_q) begin
            lo_d = value_i;
            hi_d = value_i;
          end else if (!ge_q) begin
            lo_d = prev_lo_i;
            hi_d = prev_hi_i;
          end
        end
        default: begin
          lo_d = lo_q;
          hi_d = hi_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;

endmodule

>>> design/disjoint_interval_set_insert.sv
// Add: a compare state, then an update state that applies the change and loads the result word.
// List: the list state loads the first interval, then one interval per cycle while not stalled.
// A new input word is taken only once the sequencer is back in idle after the add or list.
// Output stalls hold the update and list states; cell row compare and rotation set the pace.
// Reset clears the interval count and the sequencer; stored intervals need no clearing.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disjoint_interval_set_insert
// Sorted set of disjoint intervals kept in a row of cells, with insert,
// extend and fuse on add and an ordered stream on list.
// ----------------------------------------------------------------------------
module disjoint_interval_set_insert import dis_pkg::*; #(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
  parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  operation_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic [VALUE_BITS-1:0] range_start_o,
  output logic [VALUE_BITS-1:0] range_end_o,
  output logic [COUNT_W-1:0]    stored_count_o,
  output logic                  last_o
);

  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_LIST = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic [VALUE_BITS-1:0] v_q;
  logic                  cov_q, jl_q, jr_q;
  cell_ctrl_t            ctrl;

  logic                  out_valid_q, out_load, out_free;
  status_e               status_q, status_d;
  logic [VALUE_BITS-1:0] start_q, start_d, stop_q, stop_d;
  logic [COUNT_W-1:0]    scount_q, scount_d;
  logic                  last_q, last_d;

  logic                  in_accept;
  logic [MAX_INTERVALS-1:0] occ, ge, covered, join_l, join_r;
  logic [VALUE_BITS-1:0] cell_lo [MAX_INTERVALS];
  logic [VALUE_BITS-1:0] cell_hi [MAX_INTERVALS];

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // row of cells
  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
    localparam int PREV = (i == 0) ? 0 : i - 1;
    localparam int NEXT = (i == MAX_INTERVALS - 1) ? i : i + 1;

    assign occ[i] = (CNT_W'(i) < count_q);

    dis_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .value_i    (v_q),
      .occ_i      (occ[i]),
      .occ_next_i ((i == MAX_INTERVALS - 1) ? 1'b0 : occ[NEXT]),
      .ge_prev_i  ((i == 0) ? 1'b1 : ge[PREV]),
      .ge_next_i  ((i == MAX_INTERVALS - 1) ? 1'b0 : ge[NEXT]),
      .prev_lo_i  (cell_lo[PREV]),
      .prev_hi_i  (cell_hi[PREV]),
      .next_lo_i  (cell_lo[NEXT]),
      .next_hi_i  (cell_hi[NEXT]),
      .head_lo_i  (cell_lo[0]),
      .head_hi_i  (cell_hi[0]),
      .ge_o       (ge[i]),
      .covered_o  (covered[i]),
      .join_l_o   (join_l[i]),
      .join_r_o   (join_r[i]),
      .lo_o       (cell_lo[i]),
      .hi_o       (cell_hi[i])
    );
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    ctrl.cmp    = 1'b0;
    ctrl.upd    = 1'b0;
    ctrl.kind   = UPD_INSERT;
    ctrl.rotate = 1'b0;
    out_load    = 1'b0;
    status_d    = ST_ADDED;
    start_d     = '0;
    stop_d      = '0;
    last_d      = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_accept) state_d = (operation_i == OP_LIST) ? S_LIST : S_CMP;
      end
      S_CMP: begin
        ctrl.cmp = 1'b1;
        state_d  = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (cov_q) begin
            status_d = ST_ADDED;
          end else if (jl_q && jr_q) begin
            ctrl.upd  = 1'b1;
            ctrl.kind = UPD_FUSE;
            count_d   = count_q - CNT_W'(1);
          end else if (jl_q) begin
            ctrl.upd  = 1'b1;
            ctrl.kind = UPD_JOIN_L;
          end else if (jr_q) begin
            ctrl.upd  = 1'b1;
            ctrl.kind = UPD_JOIN_R;
          end else if (count_q == CNT_W'(MAX_INTERVALS)) begin
            status_d = ST_DROPPED;
          end else begin
            ctrl.upd  = 1'b1;
            ctrl.kind = UPD_INSERT;
            count_d   = count_q + CNT_W'(1);
          end
        end
      end
      S_LIST: begin
        if (out_free) begin
          out_load = 1'b1;
          if (count_q == '0) begin
            status_d = ST_EMPTY;
            state_d  = S_IDLE;
          end else begin
            // stream the head and rotate it to the tail
            status_d    = ST_LISTED;
            start_d     = cell_lo[0];
            stop_d      = cell_hi[0];
            ctrl.rotate = 1'b1;
            last_d      = (idx_q == count_q - CNT_W'(1));
            idx_d       = last_d ? '0 : idx_q + CNT_W'(1);
            if (last_d) state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
    scount_d = COUNT_W'(count_d);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      cov_q       <= 1'b0;
      jl_q        <= 1'b0;
      jr_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (ctrl.cmp) begin
        cov_q <= |covered;
        jl_q  <= |join_l;
        jr_q  <= |join_r;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // word value and output payload
  always_ff @(posedge clk_i) begin
    if (in_accept) v_q <= value_i;
    if (out_load) begin
      status_q <= status_d;
      start_q  <= start_d;
      stop_q   <= stop_d;
      scount_q <= scount_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign range_start_o  = start_q;
  assign range_end_o    = stop_q;
  assign stored_count_o = scount_q;
  assign last_o         = last_q;

endmodule

>>> design/dis_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dis_checker
// Port-level properties of the interval set, bound to the top level.
// ----------------------------------------------------------------------------
`include "disjoint_interval_set_insert_assert.svh"

module dis_checker import dis_pkg::*; #(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
  parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [1:0]            status_o,
  input logic [VALUE_BITS-1:0] range_start_o,
  input logic [VALUE_BITS-1:0] range_end_o,
  input logic [COUNT_W-1:0]    stored_count_o,
  input logic                  last_o
);

  // add words carry no range and close their item
  `DIS_ASSERT_IMP(a_add_word, clk_i, rst_ni,
    out_valid_o && (status_o == ST_ADDED || status_o == ST_DROPPED),
    last_o && range_start_o == '0 && range_end_o == '0)

  // an empty list reports an empty table
  `DIS_ASSERT_IMP(a_empty_list, clk_i, rst_ni,
    out_valid_o && status_o == ST_EMPTY,
    last_o && stored_count_o == '0)

  // listed intervals are well formed and the table is never overfull
  `DIS_ASSERT_IMP(a_listed_order, clk_i, rst_ni,
    out_valid_o && status_o == ST_LISTED,
    range_start_o <= range_end_o &&
    (MAX_INTERVALS >= 64 || stored_count_o <= COUNT_W'(MAX_INTERVALS)))

  // a stalled word holds
  `DIS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni,
    out_valid_o && out_stall_i,
    out_valid_o && $stable(status_o) && $stable(range_start_o) && $stable(last_o))

endmodule

bind disjoint_interval_set_insert dis_checker #(
  .MAX_INTERVALS(MAX_INTERVALS),
  .VALUE_BITS   (VALUE_BITS)
) u_dis_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .range_start_o (range_start_o),
  .range_end_o   (range_end_o),
  .stored_count_o(stored_count_o),
  .last_o        (last_o)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for disjoint_interval_set_insert. Adds and list requests are
// driven through the valid/stall input channel. A local copy of the sorted
// interval table predicts every result word. Each word taken from the output
// channel is compared against the oldest prediction. Directed corner cases
// run first, then back-pressure and random sequences built around the
// stored intervals.
// ----------------------------------------------------------------------------
module tb;
  import dis_pkg::*;

  localparam int VB       = VALUE_BITS_DEF;
  localparam int SLOTS    = MAX_INTERVALS_DEF;
  localparam int HOLD_LEN = 300;
  localparam int WDOG_MAX = 4000;

  typedef struct {
    status_e             status;
    logic [VB-1:0]       lo;
    logic [VB-1:0]       hi;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } result_word_t;

  // DUT I/O, inputs at known values from time zero
  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic               operation_i    = OP_ADD;
  logic [VB-1:0]      value_i        = '0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic [1:0]         status_o;
  logic [VB-1:0]      range_start_o;
  logic [VB-1:0]      range_end_o;
  logic [COUNT_W-1:0] stored_count_o;
  logic               last_o;

  // local copy of the interval table
  logic [VB-1:0] set_lo [SLOTS];
  logic [VB-1:0] set_hi [SLOTS];
  int            set_count = 0;

  result_word_t pending_words[$];
  int           error_count = 0;

  // sender / receiver pacing controls
  bit tx_gaps_on  = 1'b1;
  bit rx_stall_on = 1'b1;
  bit hold_req    = 1'b0;
  int hold_left   = 0;
  int rx_run_left = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  disjoint_interval_set_insert dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .range_start_o  (range_start_o),
    .range_end_o    (range_end_o),
    .stored_count_o (stored_count_o),
    .last_o         (last_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Insert one value into the local table; returns the add status.
  function automatic status_e insert_value(logic [VB-1:0] v);
    int  pos;
    int  i;
    bit  join_l;
    bit  join_r;
    pos = 0;
    while (pos < set_count && set_lo[pos] <= v) pos++;
    // already covered
    if (pos > 0 && set_hi[pos-1] >= v) return ST_ADDED;
    // adjacency in int width, so the top value never wraps
    join_l = (pos > 0) && (int'(set_hi[pos-1]) + 1 == int'(v));
    join_r = (pos < set_count) && (int'(set_lo[pos]) == int'(v) + 1);
    if (join_l && join_r) begin
      set_hi[pos-1] = set_hi[pos];
      for (i = pos; i + 1 < set_count; i++) begin
        set_lo[i] = set_lo[i+1];
        set_hi[i] = set_hi[i+1];
      end
      set_count--;
      return ST_ADDED;
    end
    if (join_l) begin
      set_hi[pos-1] = v;
      return ST_ADDED;
    end
    if (join_r) begin
      set_lo[pos] = v;
      return ST_ADDED;
    end
    if (set_count >= SLOTS) return ST_DROPPED;
    for (i = set_count; i > pos; i--) begin
      set_lo[i] = set_lo[i-1];
      set_hi[i] = set_hi[i-1];
    end
    set_lo[pos] = v;
    set_hi[pos] = v;
    set_count++;
    return ST_ADDED;
  endfunction

  // Queue the result words one accepted input word produces.
  function automatic void predict_results(logic op, logic [VB-1:0] v);
    result_word_t w;
    int           i;
    w.lo    = '0;
    w.hi    = '0;
    w.last  = 1'b1;
    if (op == OP_ADD) begin
      w.status = insert_value(v);
      w.count  = set_count[COUNT_W-1:0];
      pending_words.insert(pending_words.size(), w);
    end else if (set_count == 0) begin
      w.status = ST_EMPTY;
      w.count  = '0;
      pending_words.insert(pending_words.size(), w);
    end else begin
      for (i = 0; i < set_count; i++) begin
        w.status = ST_LISTED;
        w.lo     = set_lo[i];
        w.hi     = set_hi[i];
        w.count  = set_count[COUNT_W-1:0];
        w.last   = (i + 1 == set_count);
        pending_words.insert(pending_words.size(), w);
      end
    end
  endfunction

  // Value picked around the stored intervals so extends, fuses and hits occur.
  function automatic logic [VB-1:0] pick_value();
    int k;
    int i;
    k = $urandom_range(0, 99);
    if (set_count == 0 || k < 20) return VB'($urandom);
    i = $urandom_range(0, set_count - 1);
    if (k < 45) return set_hi[i] + 1'b1;
    if (k < 70) return set_lo[i] - 1'b1;
    if (k < 85) return VB'($urandom_range(set_lo[i], set_hi[i]));
    return set_hi[i] + 2'd2;
  endfunction

  // Send one word; returns at the edge where it is accepted.
  task automatic send_word(logic op, logic [VB-1:0] v);
    if (tx_gaps_on) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = $urandom_range(1, 10);
      end
      burst_left--;
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    value_i     <= v;
    do @(posedge clk_i); while (in_stall_o);
    predict_results(op, v);
  endtask

  // Pause the sender until every predicted word has arrived.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_words.size() != 0);
  endtask

  task automatic test_empty_list();
    send_word(OP_LIST, VB'($urandom));
    wait_drained();
  endtask

  // Range ends, top value not adjacent to zero, extend both ways, fuse, covered
  task automatic test_range_edges();
    send_word(OP_ADD, '1);
    send_word(OP_ADD, '0);
    send_word(OP_ADD, VB'(16'hFFFE));
    send_word(OP_ADD, VB'(16'h0001));
    send_word(OP_ADD, VB'(16'h0003));
    send_word(OP_ADD, VB'(16'h0002));
    send_word(OP_ADD, VB'(16'h0002));
    send_word(OP_ADD, VB'(16'h5555));
    send_word(OP_ADD, VB'(16'hAAAA));
    send_word(OP_LIST, '1);
    wait_drained();
  endtask

  // Fill every slot, then drop, hit and extend while full
  task automatic test_table_full();
    int i;
    while (set_count < SLOTS) send_word(OP_ADD, VB'($urandom));
    send_word(OP_LIST, VB'($urandom));
    for (i = 0; i + 1 < set_count; i++) begin
      if (int'(set_lo[i+1]) - int'(set_hi[i]) >= 4) begin
        send_word(OP_ADD, set_hi[i] + 2'd2);
        break;
      end
    end
    send_word(OP_ADD, set_lo[3]);
    send_word(OP_ADD, set_hi[5] + 1'b1);
    send_word(OP_LIST, '0);
    wait_drained();
  endtask

  // Long receiver hold while the sender keeps offering back to back
  task automatic test_backpressure();
    int n;
    tx_gaps_on = 1'b0;
    hold_req   = 1'b1;
    for (n = 0; n < 24; n++) begin
      if (n % 8 == 7) send_word(OP_LIST, VB'($urandom));
      else send_word(OP_ADD, pick_value());
    end
    wait_drained();
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_mix(int n_words);
    int n;
    for (n = 0; n < n_words; n++) begin
      // a stretch with neither side idling
      tx_gaps_on  = (n >= 40);
      rx_stall_on = (n >= 40);
      if ($urandom_range(0, 99) < 15) send_word(OP_LIST, VB'($urandom));
      else send_word(OP_ADD, pick_value());
    end
    wait_drained();
  endtask

  // Receiver stall pattern: alternating runs, plus a counted long hold
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_LEN;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!rx_stall_on) begin
      out_stall_i <= 1'b0;
    end else if (rx_run_left > 0) begin
      rx_run_left--;
    end else if (out_stall_i) begin
      out_stall_i <= 1'b0;
      rx_run_left = $urandom_range(0, 12);
    end else begin
      out_stall_i <= 1'b1;
      rx_run_left = $urandom_range(0, 4);
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin
    result_word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word status=%0d start=%0h end=%0h count=%0d last=%0b",
                 $time, status_o, range_start_o, range_end_o, stored_count_o, last_o);
        error_count++;
      end else begin
        w = pending_words.pop_front();
        if (status_o !== w.status || range_start_o !== w.lo || range_end_o !== w.hi ||
            stored_count_o !== w.count || last_o !== w.last) begin
          $display("%0t: mismatch expected status=%0d start=%0h end=%0h count=%0d last=%0b",
                   $time, w.status, w.lo, w.hi, w.count, w.last);
          $display("%0t:          actual   status=%0d start=%0h end=%0h count=%0d last=%0b",
                   $time, status_o, range_start_o, range_end_o, stored_count_o, last_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WDOG_MAX) begin
        $display("%0t: no progress for %0d cycles", $time, WDOG_MAX);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Test sequence
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_range_edges();
    test_table_full();
    test_backpressure();
    test_random_mix(180);
    repeat (20) @(posedge clk_i);
    if (error_count == 0 && pending_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/dis_pkg.sv
design/dis_cell.sv
design/disjoint_interval_set_insert.sv
design/dis_checker.sv
tb/tb.sv
